// ===== design/sidk_pkg.sv =====
// Shared widths, types and register indexes for the softened inverse-distance kernel.
`timescale 1ns / 1ps
`default_nettype none
package sidk_pkg;
    localparam int COORD_W = 24;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int ETA_W   = 32;
    localparam int DEN_W   = ETA_W + 1;
    localparam int Q_W     = 32;
    localparam int REM_W   = DEN_W + 1;
    localparam int DIMS_W  = 2;
    localparam int NUM_COORDS = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [ETA_W-1:0]  eta_t;
    typedef logic [DEN_W-1:0]  den_t;
    typedef logic [Q_W-1:0]    quot_t;
    typedef logic [DIMS_W-1:0] dims_t;

    typedef enum logic [1:0] {
        REG_SOFTENING = 2'd0,
        REG_DIMS      = 2'd1
    } reg_index_t;
endpackage
`default_nettype wire

// ===== design/sidk_lane.sv =====
// One coordinate lane: difference, magnitude and square of one dimension.
`timescale 1ns / 1ps
`default_nettype none
module sidk_lane (
    input  wire logic            clk,
    input  wire logic            adv,
    input  wire logic            lane_on,
    input  wire sidk_pkg::coord_t row_c,
    input  wire sidk_pkg::coord_t col_c,
    output sidk_pkg::sq_t        sq_reg
);
    import sidk_pkg::*;

    logic signed [COORD_W:0] diff;
    logic [MAG_W-1:0]        mag;
    sq_t                     sq_next;

    always_comb
    begin
        diff = {row_c[COORD_W-1], row_c} - {col_c[COORD_W-1], col_c};
        // |diff| never exceeds 2^24-1, so it fits the magnitude width
        mag  = diff[COORD_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
        sq_next = lane_on ? (SQ_W'(mag) * SQ_W'(mag)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= sq_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/sidk_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module sidk_sqrt (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_vld,
    input  wire sidk_pkg::sum_t sum_in,
    output logic                out_vld,
    output sidk_pkg::root_t     root_out
);
    import sidk_pkg::*;

    logic [SUM_W:0] rem_reg  [0:ROOT_W];
    root_t          root_reg [0:ROOT_W];
    logic           vld_reg  [0:ROOT_W];

    assign rem_reg[0]  = {1'b0, sum_in};
    assign root_reg[0] = '0;
    assign vld_reg[0]  = in_vld;

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic [SUM_W:0] trial;
        assign trial = ((SUM_W+1)'(root_reg[s]) << (B + 1))
                     | ((SUM_W+1)'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem_reg[s] >= trial)
                begin
                    rem_reg[s+1]  <= rem_reg[s] - trial;
                    root_reg[s+1] <= root_reg[s] | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[s+1]  <= rem_reg[s];
                    root_reg[s+1] <= root_reg[s];
                end
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W];
    assign root_out = root_reg[ROOT_W];
endmodule
`default_nettype wire

// ===== design/sidk_recip.sv =====
// Pipelined restoring divider for floor(2^32 / D), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module sidk_recip (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_vld,
    input  wire sidk_pkg::den_t den_in,
    output logic                out_vld,
    output logic                out_sat,
    output sidk_pkg::quot_t     quot_out
);
    import sidk_pkg::*;

    logic [REM_W-1:0] rem_reg [0:Q_W];
    quot_t            q_reg   [0:Q_W];
    den_t             den_reg [0:Q_W];
    logic             sat_reg [0:Q_W];
    logic             vld_reg [0:Q_W];

    // top quotient bit already resolved: remainder 1, quotient bit 0 for D >= 2
    assign rem_reg[0] = REM_W'(1);
    assign q_reg[0]   = '0;
    assign den_reg[0] = den_in;
    assign sat_reg[0] = (den_in <= DEN_W'(1));
    assign vld_reg[0] = in_vld;

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        localparam int B = Q_W - 1 - s;
        logic [REM_W-1:0] shifted;
        assign shifted = rem_reg[s] << 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[s+1] <= den_reg[s];
                sat_reg[s+1] <= sat_reg[s];
                if (shifted >= REM_W'(den_reg[s]))
                begin
                    rem_reg[s+1] <= shifted - REM_W'(den_reg[s]);
                    q_reg[s+1]   <= q_reg[s] | (Q_W'(1) << B);
                end
                else
                begin
                    rem_reg[s+1] <= shifted;
                    q_reg[s+1]   <= q_reg[s];
                end
            end
        end
    end

    assign out_vld  = vld_reg[Q_W];
    assign out_sat  = sat_reg[Q_W];
    assign quot_out = sat_reg[Q_W] ? '1 : q_reg[Q_W];
endmodule
`default_nettype wire

// ===== design/softened_inverse_distance_kernel.sv =====
// Top level: softened inverse-distance kernel, lanes, square root and reciprocal.
//
//  channel | signals                                  | direction | transfer when
//  --------+------------------------------------------+-----------+-------------------
//  in      | in_valid, in_stall, row_*, col_*         | in        | valid & !stall
//  out     | out_valid, out_stall, interaction, sat.  | out       | valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | valid & ready
//
// One point pair enters per cycle unless stalled; each result passes through
// 1 lane stage, 25 square-root stages, 1 denominator stage, 32 divider stages
// and 1 output register. Latency is set by the bit-per-stage root and divider.
// Reset clears all valid bits and loads the register defaults (eta 0, 3 dims).
// A held output stalls the whole pipeline; in_stall rises in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module softened_inverse_distance_kernel #(
    parameter int MAX_DIMENSIONS = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire sidk_pkg::coord_t row_x,
    input  wire sidk_pkg::coord_t row_y,
    input  wire sidk_pkg::coord_t row_z,
    input  wire sidk_pkg::coord_t col_x,
    input  wire sidk_pkg::coord_t col_y,
    input  wire sidk_pkg::coord_t col_z,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output sidk_pkg::quot_t       interaction,
    output logic                  saturated,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_data
);
    import sidk_pkg::*;

    localparam dims_t MAX_D = DIMS_W'(MAX_DIMENSIONS);

    // configuration registers
    eta_t  softening_reg;
    dims_t dims_reg;

    // pipeline advance: everything moves when the output slot is free or leaving
    logic adv;
    logic out_valid_reg;
    quot_t interaction_reg;
    logic  saturated_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            softening_reg <= '0;
            dims_reg      <= 2'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOFTENING: softening_reg <= cfg_data[ETA_W-1:0];
                REG_DIMS:      dims_reg      <= cfg_data[DIMS_W-1:0];
                default:       ;
            endcase
        end
    end

    // clip the dimension count to the lanes that exist
    dims_t n_eff;
    assign n_eff = (dims_reg > MAX_D) ? MAX_D : dims_reg;

    coord_t row_c [0:NUM_COORDS-1];
    coord_t col_c [0:NUM_COORDS-1];
    assign row_c[0] = row_x;
    assign row_c[1] = row_y;
    assign row_c[2] = row_z;
    assign col_c[0] = col_x;
    assign col_c[1] = col_y;
    assign col_c[2] = col_z;

    // one lane per dimension
    sq_t  sq   [0:MAX_DIMENSIONS-1];
    logic lane_vld_reg;

    for (genvar k = 0; k < MAX_DIMENSIONS; k++)
    begin : g_lane
        sidk_lane u_lane (
            .clk     (clk),
            .adv     (adv),
            .lane_on (DIMS_W'(k) < n_eff),
            .row_c   (row_c[k]),
            .col_c   (col_c[k]),
            .sq_reg  (sq[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            lane_vld_reg <= in_valid;
        end
    end

    // merge: sum of the lane squares
    sum_t sum_all;
    always_comb
    begin
        sum_all = '0;
        for (int k = 0; k < MAX_DIMENSIONS; k++)
        begin
            sum_all = sum_all + SUM_W'(sq[k]);
        end
    end

    logic  root_vld;
    root_t root;

    sidk_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (lane_vld_reg),
        .sum_in   (sum_all),
        .out_vld  (root_vld),
        .root_out (root)
    );

    // denominator: distance plus eta
    den_t den_reg;
    logic den_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            den_vld_reg <= root_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg <= DEN_W'(root) + DEN_W'(softening_reg);
        end
    end

    logic  div_vld;
    logic  div_sat;
    quot_t div_q;

    sidk_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (den_vld_reg),
        .den_in   (den_reg),
        .out_vld  (div_vld),
        .out_sat  (div_sat),
        .quot_out (div_q)
    );

    // output register: hold while stalled, advance otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            interaction_reg <= div_q;
            saturated_reg   <= div_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign interaction = interaction_reg;
    assign saturated   = saturated_reg;

    a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> interaction == '1)
        else $error("saturated result is not all ones");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> lane_vld_reg)
        else $error("accepted pair did not enter the lanes");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(div_vld) && $stable(den_vld_reg))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
